// ===== sv/dmip_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the dual motor incremental PID unit.
// No dependencies.
package dmip_pkg;

  localparam int GAIN_W     = 24;
  localparam int DUTY_W     = 10;
  localparam int PERIOD_W   = 16;
  localparam int PULSE_W    = 16;
  localparam int SUM_W      = 32;
  localparam int ERR_W      = SUM_W + 1;            // target - measured, exact
  localparam int COEF_W     = GAIN_W + 2;           // p+i+d and p+2d
  localparam int PROD_W     = COEF_W + 1 + ERR_W;   // signed coef times error
  localparam int INC_W      = PROD_W + 2;           // sum of three products
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = GAIN_W;

  localparam logic [GAIN_W-1:0]   GAIN_P_RST = GAIN_W'(4915200);  // 75.0
  localparam logic [GAIN_W-1:0]   GAIN_I_RST = GAIN_W'(39);       // ~0.0006
  localparam logic [GAIN_W-1:0]   GAIN_D_RST = GAIN_W'(589824);   // 9.0
  localparam logic [DUTY_W-1:0]   DUTY_MAX_RST = DUTY_W'(220);
  localparam logic [PERIOD_W-1:0] PERIOD_RST = PERIOD_W'(8);

  localparam logic [COEF_W-1:0] COEF_A_RST =
    COEF_W'(GAIN_P_RST) + COEF_W'(GAIN_I_RST) + COEF_W'(GAIN_D_RST);
  localparam logic [COEF_W-1:0] COEF_B_RST =
    COEF_W'(GAIN_P_RST) + (COEF_W'(GAIN_D_RST) << 1);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_GAIN_P        = 3'd0,
    CFG_GAIN_I        = 3'd1,
    CFG_GAIN_D        = 3'd2,
    CFG_DUTY_MAX      = 3'd3,
    CFG_SAMPLE_PERIOD = 3'd4
  } cfg_idx_e;

  typedef struct packed {
    logic                      mode;
    logic signed [PULSE_W-1:0] left_pulses;
    logic signed [PULSE_W-1:0] right_pulses;
    logic signed [PULSE_W-1:0] left_target;
    logic signed [PULSE_W-1:0] right_target;
  } dmip_in_t;

  typedef struct packed {
    logic [DUTY_W-1:0] left_duty;
    logic [DUTY_W-1:0] right_duty;
  } dmip_out_t;

endpackage

// ===== sv/dual_motor_incremental_pid_unit.sv =====
`timescale 1ns / 1ps
// Two-wheel incremental (velocity form) PID speed regulator, top level.
// Depends on dmip_pkg.
//
//  channel  | signals                           | moves
//  ---------+-----------------------------------+-------------------------------
//  in       | in_valid_i in_ready_o in_data_i   | tick (mode 0) or control step
//  out      | out_valid_o out_ready_i out_data_o| clamped duties, one per control
//  cfg      | cfg_we_i cfg_idx_i cfg_wdata_i    | register write, no wait
//
// One transaction per cycle while in_ready_o is high. Ticks update the pulse
// sums on acceptance and give no result. A control step shifts the error
// history on acceptance; its duties then move on to the output register
// (history -> products -> increment -> accumulate/saturate/clamp). Each stage
// holds while the one after it is full and stalled; in_ready_o drops only
// when the whole chain up to the output register is full. Reset restores the
// register defaults, clearing all but product, increment, duty data at once.
module dual_motor_incremental_pid_unit
  import dmip_pkg::*;
#(
  parameter int GAIN_FRAC_BITS = 16,
  parameter int DRIVE_WIDTH    = 24
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  dmip_in_t              in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output dmip_out_t             out_data_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DATA_W-1:0] cfg_wdata_i
);

  localparam int Q_W  = INC_W - GAIN_FRAC_BITS;
  localparam int ND_W = Q_W + 1;

  // configuration
  logic [GAIN_W-1:0]   gain_p_q, gain_p_d, gain_i_q, gain_i_d, gain_d_q, gain_d_d;
  logic [DUTY_W-1:0]   duty_max_q, duty_max_d;
  logic [PERIOD_W-1:0] period_q, period_d;
  logic [COEF_W-1:0]   coef_a_q, coef_a_d, coef_b_q, coef_b_d;

  // measurement and history
  logic [PERIOD_W-1:0]     tick_q, tick_d, tick_inc;
  logic [SUM_W-1:0]        lsum_q, lsum_d, rsum_q, rsum_d, lsum_add, rsum_add;
  logic signed [SUM_W-1:0] lmeas_q, lmeas_d, rmeas_q, rmeas_d;
  logic signed [ERR_W-1:0] hist_l_q [3];
  logic signed [ERR_W-1:0] hist_l_d [3];
  logic signed [ERR_W-1:0] hist_r_q [3];
  logic signed [ERR_W-1:0] hist_r_d [3];

  // pipeline
  logic v1_q, v2_q, v3_q, out_valid_q;
  logic r1, r2, r3, r_out, in_fire;
  logic signed [COEF_W:0]  ca, cb, cd;
  logic signed [PROD_W-1:0] pla_q, plb_q, pld_q, pra_q, prb_q, prd_q;
  logic signed [INC_W-1:0]  inc_l_q, inc_r_q;
  logic signed [DRIVE_WIDTH-1:0] drv_l_q, drv_r_q, drv_l_d, drv_r_d;
  dmip_out_t out_q;

  function automatic logic signed [DRIVE_WIDTH-1:0] drv_next(
    input logic signed [DRIVE_WIDTH-1:0] drv,
    input logic signed [INC_W-1:0]       inc
  );
    logic signed [Q_W-1:0]     q_fl;
    logic                      corr;
    logic signed [ND_W-1:0]    nd;
    logic [ND_W-DRIVE_WIDTH:0] top;
    q_fl = $signed(inc[INC_W-1:GAIN_FRAC_BITS]);
    // floor plus one for negative values with a remainder: truncation to zero
    corr = inc[INC_W-1] & (|inc[GAIN_FRAC_BITS-1:0]);
    nd   = ND_W'(drv) + ND_W'(q_fl) + ND_W'(corr);
    top  = nd[ND_W-1:DRIVE_WIDTH-1];
    if ((&top) || !(|top)) begin
      return $signed(nd[DRIVE_WIDTH-1:0]);
    end else if (nd[ND_W-1]) begin
      return $signed({1'b1, {(DRIVE_WIDTH-1){1'b0}}});
    end else begin
      return $signed({1'b0, {(DRIVE_WIDTH-1){1'b1}}});
    end
  endfunction

  function automatic logic [DUTY_W-1:0] duty_of(
    input logic signed [DRIVE_WIDTH-1:0] drv,
    input logic [DUTY_W-1:0]             dmax
  );
    if (drv[DRIVE_WIDTH-1] || (drv == '0)) begin
      return '0;
    end else if (drv[DRIVE_WIDTH-2:0] >= (DRIVE_WIDTH-1)'(dmax)) begin
      return dmax;
    end else begin
      return drv[DUTY_W-1:0];
    end
  endfunction

  // ---------------- handshake chain ----------------
  assign r_out      = !out_valid_q || out_ready_i;
  assign r3         = !v3_q || r_out;
  assign r2         = !v2_q || r3;
  assign r1         = !v1_q || r2;
  assign in_ready_o = r1;
  assign in_fire    = in_valid_i && r1;

  // ---------------- configuration ----------------
  always_comb begin
    gain_p_d   = gain_p_q;
    gain_i_d   = gain_i_q;
    gain_d_d   = gain_d_q;
    duty_max_d = duty_max_q;
    period_d   = period_q;
    if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_GAIN_P:        gain_p_d   = cfg_wdata_i;
        CFG_GAIN_I:        gain_i_d   = cfg_wdata_i;
        CFG_GAIN_D:        gain_d_d   = cfg_wdata_i;
        CFG_DUTY_MAX:      duty_max_d = cfg_wdata_i[DUTY_W-1:0];
        CFG_SAMPLE_PERIOD: period_d   = cfg_wdata_i[PERIOD_W-1:0];
        default: ;
      endcase
    end
    coef_a_d = COEF_W'(gain_p_d) + COEF_W'(gain_i_d) + COEF_W'(gain_d_d);
    coef_b_d = COEF_W'(gain_p_d) + (COEF_W'(gain_d_d) << 1);
  end

  // ---------------- ticks and error history ----------------
  always_comb begin
    tick_inc = tick_q + PERIOD_W'(1);
    lsum_add = lsum_q + SUM_W'(in_data_i.left_pulses);
    rsum_add = rsum_q + SUM_W'(in_data_i.right_pulses);
    tick_d   = tick_q;
    lsum_d   = lsum_q;
    rsum_d   = rsum_q;
    lmeas_d  = lmeas_q;
    rmeas_d  = rmeas_q;
    hist_l_d = hist_l_q;
    hist_r_d = hist_r_q;
    if (in_fire && !in_data_i.mode) begin
      if (tick_inc >= period_q) begin
        lmeas_d = $signed(lsum_add);
        rmeas_d = $signed(-rsum_add);
        tick_d  = '0;
        lsum_d  = '0;
        rsum_d  = '0;
      end else begin
        tick_d  = tick_inc;
        lsum_d  = lsum_add;
        rsum_d  = rsum_add;
      end
    end else if (in_fire) begin
      hist_l_d[2] = hist_l_q[1];
      hist_l_d[1] = hist_l_q[0];
      hist_l_d[0] = ERR_W'(in_data_i.left_target) - ERR_W'(lmeas_q);
      hist_r_d[2] = hist_r_q[1];
      hist_r_d[1] = hist_r_q[0];
      hist_r_d[0] = ERR_W'(in_data_i.right_target) - ERR_W'(rmeas_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      gain_p_q   <= GAIN_P_RST;
      gain_i_q   <= GAIN_I_RST;
      gain_d_q   <= GAIN_D_RST;
      duty_max_q <= DUTY_MAX_RST;
      period_q   <= PERIOD_RST;
      coef_a_q   <= COEF_A_RST;
      coef_b_q   <= COEF_B_RST;
      tick_q     <= '0;
      lsum_q     <= '0;
      rsum_q     <= '0;
      lmeas_q    <= '0;
      rmeas_q    <= '0;
      hist_l_q   <= '{default: '0};
      hist_r_q   <= '{default: '0};
      drv_l_q    <= '0;
      drv_r_q    <= '0;
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      v3_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      gain_p_q   <= gain_p_d;
      gain_i_q   <= gain_i_d;
      gain_d_q   <= gain_d_d;
      duty_max_q <= duty_max_d;
      period_q   <= period_d;
      coef_a_q   <= coef_a_d;
      coef_b_q   <= coef_b_d;
      tick_q     <= tick_d;
      lsum_q     <= lsum_d;
      rsum_q     <= rsum_d;
      lmeas_q    <= lmeas_d;
      rmeas_q    <= rmeas_d;
      hist_l_q   <= hist_l_d;
      hist_r_q   <= hist_r_d;
      drv_l_q    <= drv_l_d;
      drv_r_q    <= drv_r_d;
      if (r1) begin
        v1_q <= in_fire && in_data_i.mode;
      end
      if (r2) begin
        v2_q <= v1_q;
      end
      if (r3) begin
        v3_q <= v2_q;
      end
      if (r_out) begin
        out_valid_q <= v3_q;
      end
    end
  end

  // ---------------- products ----------------
  assign ca = $signed({1'b0, coef_a_q});
  assign cb = $signed({1'b0, coef_b_q});
  assign cd = $signed({{(COEF_W+1-GAIN_W){1'b0}}, gain_d_q});

  always_ff @(posedge clk_i) begin
    if (v1_q && r2) begin
      pla_q <= ca * hist_l_q[0];
      plb_q <= cb * hist_l_q[1];
      pld_q <= cd * hist_l_q[2];
      pra_q <= ca * hist_r_q[0];
      prb_q <= cb * hist_r_q[1];
      prd_q <= cd * hist_r_q[2];
    end
  end

  // ---------------- increment ----------------
  always_ff @(posedge clk_i) begin
    if (v2_q && r3) begin
      inc_l_q <= INC_W'(pla_q) - INC_W'(plb_q) + INC_W'(pld_q);
      inc_r_q <= INC_W'(pra_q) - INC_W'(prb_q) + INC_W'(prd_q);
    end
  end

  // ---------------- accumulate, saturate, clamp ----------------
  always_comb begin
    drv_l_d = drv_l_q;
    drv_r_d = drv_r_q;
    if (v3_q && r_out) begin
      drv_l_d = drv_next(drv_l_q, inc_l_q);
      drv_r_d = drv_next(drv_r_q, inc_r_q);
    end
  end

  always_ff @(posedge clk_i) begin
    if (v3_q && r_out) begin
      out_q.left_duty  <= duty_of(drv_l_d, duty_max_q);
      out_q.right_duty <= duty_of(drv_r_d, duty_max_q);
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- assertions ----------------
  a_ctrl_enters_pipe: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> (v1_q == $past(in_data_i.mode)))
    else $error("pipeline entry does not match transaction mode");

  a_hist_shift: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && in_data_i.mode) |=>
      (hist_l_q[1] == $past(hist_l_q[0]) && hist_l_q[2] == $past(hist_l_q[1]) &&
       hist_r_q[1] == $past(hist_r_q[0]) && hist_r_q[2] == $past(hist_r_q[1])))
    else $error("error history did not shift on control step");

  a_tick_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_fire && !in_data_i.mode && !cfg_we_i) |=>
      (tick_q == '0 || tick_q < period_q))
    else $error("tick count left at or above sample period");

  a_stage3_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (v3_q && !r_out) |=> (v3_q && $stable(inc_l_q) && $stable(inc_r_q)))
    else $error("increment stage lost data during output stall");

endmodule

// ===== test/tb.sv =====
`timescale 1ns / 1ps
// Testbench for dual_motor_incremental_pid_unit: directed and random ticks and
// control steps, duties checked against a speed-loop predictor kept in the bench.
// Depends on dmip_pkg and the unit's top level.
module tb;
  import dmip_pkg::*;

  localparam int          FRAC_BITS     = 16;
  localparam int          DRIVE_W       = 24;
  localparam longint      DRIVE_HI      = (longint'(1) << (DRIVE_W - 1)) - 1;
  localparam longint      DRIVE_LO      = -DRIVE_HI - 1;
  localparam logic        MODE_TICK     = 1'b0;
  localparam logic        MODE_CTRL     = 1'b1;
  localparam int          LEFT          = 0;
  localparam int          RIGHT         = 1;
  localparam int          PIPE_LATENCY  = 3;
  localparam int          SETTLE_CYCLES = PIPE_LATENCY + 5;
  localparam int unsigned CYCLE_LIMIT   = 400000;
  localparam int unsigned DRAIN_LIMIT   = 20000;
  localparam int          MAX_PRINTS    = 40;

  localparam logic signed [PULSE_W-1:0] WORD_MAX = {1'b0, {(PULSE_W-1){1'b1}}};
  localparam logic signed [PULSE_W-1:0] WORD_MIN = {1'b1, {(PULSE_W-1){1'b0}}};
  localparam logic [GAIN_W-1:0]         GAIN_MAX = '1;
  localparam logic [DUTY_W-1:0]         DUTY_TOP = '1;
  localparam int                        CFG_IDX_FIRST_UNUSED = CFG_SAMPLE_PERIOD + 1;

  logic                  clk_i       = 1'b0;
  logic                  rst_ni      = 1'b0;
  logic                  in_valid_i  = 1'b0;
  logic                  in_ready_o;
  dmip_in_t              in_data_i   = '0;
  logic                  out_valid_o;
  logic                  out_ready_i = 1'b0;
  dmip_out_t             out_data_o;
  logic                  cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_wdata_i = '0;

  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          hold_off_left  = 0;
  int          error_count    = 0;
  int unsigned cycle_count    = 0;

  // predictor copy of registers and loop state
  logic [GAIN_W-1:0]   gain_p_m, gain_i_m, gain_d_m;
  logic [DUTY_W-1:0]   duty_max_m;
  logic [PERIOD_W-1:0] period_m;
  logic [PERIOD_W-1:0] tick_cnt_m;
  logic [SUM_W-1:0]    pulse_sum_m[2];
  logic [SUM_W-1:0]    speed_m[2];
  longint              err_hist_m[2][3];
  longint              drive_m[2];
  dmip_out_t           expected_duties[$];
  dmip_out_t           duty_want;

  dual_motor_incremental_pid_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end
  end

  task automatic report_mismatch(input string msg);
    if (error_count < MAX_PRINTS) $display("%0t: mismatch: %s", $time, msg);
    error_count++;
  endtask

  function automatic void reset_model();
    gain_p_m   = GAIN_P_RST;
    gain_i_m   = GAIN_I_RST;
    gain_d_m   = GAIN_D_RST;
    duty_max_m = DUTY_MAX_RST;
    period_m   = PERIOD_RST;
    tick_cnt_m = '0;
    for (int w = 0; w < 2; w++) begin
      pulse_sum_m[w] = '0;
      speed_m[w]     = '0;
      drive_m[w]     = 0;
      for (int k = 0; k < 3; k++) err_hist_m[w][k] = 0;
    end
  endfunction

  // velocity-form PID step for one wheel; returns the clamped duty
  function automatic logic [DUTY_W-1:0] wheel_duty(input int w, input longint target);
    longint kp, ki, kd, incr, nd;
    kp = longint'(gain_p_m);
    ki = longint'(gain_i_m);
    kd = longint'(gain_d_m);
    err_hist_m[w][2] = err_hist_m[w][1];
    err_hist_m[w][1] = err_hist_m[w][0];
    err_hist_m[w][0] = target - longint'($signed(speed_m[w]));
    incr = (kp + ki + kd) * err_hist_m[w][0] - (kp + 2 * kd) * err_hist_m[w][1]
         + kd * err_hist_m[w][2];
    // signed divide truncates toward zero
    nd = drive_m[w] + incr / (longint'(1) << FRAC_BITS);
    if (nd > DRIVE_HI) nd = DRIVE_HI;
    if (nd < DRIVE_LO) nd = DRIVE_LO;
    drive_m[w] = nd;
    if (nd <= 0) return '0;
    if (nd >= longint'(duty_max_m)) return duty_max_m;
    return DUTY_W'(nd);
  endfunction

  function automatic void predict_item(input dmip_in_t item);
    dmip_out_t duty;
    if (item.mode == MODE_TICK) begin
      tick_cnt_m         = tick_cnt_m + 1'b1;
      pulse_sum_m[LEFT]  = pulse_sum_m[LEFT] + SUM_W'(item.left_pulses);
      pulse_sum_m[RIGHT] = pulse_sum_m[RIGHT] + SUM_W'(item.right_pulses);
      if (tick_cnt_m >= period_m) begin
        speed_m[LEFT]      = pulse_sum_m[LEFT];
        speed_m[RIGHT]     = -pulse_sum_m[RIGHT];
        tick_cnt_m         = '0;
        pulse_sum_m[LEFT]  = '0;
        pulse_sum_m[RIGHT] = '0;
      end
    end else begin
      duty.left_duty  = wheel_duty(LEFT, item.left_target);
      duty.right_duty = wheel_duty(RIGHT, item.right_target);
      expected_duties.push_back(duty);
    end
  endfunction

  function automatic logic signed [PULSE_W-1:0] rand_word(input int spread);
    int v;
    case ($urandom_range(9))
      0: return PULSE_W'($urandom);
      1: return $urandom_range(1) ? WORD_MAX : WORD_MIN;
      default: begin
        v = $urandom_range(2 * spread);
        v = v - spread;
        return PULSE_W'(v);
      end
    endcase
  endfunction

  // unused fields always carry random junk
  function automatic dmip_in_t tick_item(input logic signed [PULSE_W-1:0] l,
                                         input logic signed [PULSE_W-1:0] r);
    dmip_in_t it;
    it.mode         = MODE_TICK;
    it.left_pulses  = l;
    it.right_pulses = r;
    it.left_target  = PULSE_W'($urandom);
    it.right_target = PULSE_W'($urandom);
    return it;
  endfunction

  function automatic dmip_in_t ctrl_item(input logic signed [PULSE_W-1:0] l,
                                         input logic signed [PULSE_W-1:0] r);
    dmip_in_t it;
    it.mode         = MODE_CTRL;
    it.left_pulses  = PULSE_W'($urandom);
    it.right_pulses = PULSE_W'($urandom);
    it.left_target  = l;
    it.right_target = r;
    return it;
  endfunction

  function automatic logic [GAIN_W-1:0] random_gain();
    case ($urandom_range(7))
      0: return '0;
      1: return GAIN_MAX;
      2: return GAIN_W'($urandom);
      default: return GAIN_W'($urandom_range(1 << 18));
    endcase
  endfunction

  // returns right after acceptance; caller must send again or drain in the same step
  task automatic send_item(input dmip_in_t item);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    predict_item(item);
  endtask

  task automatic drain();
    int unsigned waited;
    waited = 0;
    in_valid_i <= 1'b0;
    while (expected_duties.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (expected_duties.size() != 0) begin
      report_mismatch($sformatf("%0d expected duty pairs never arrived",
                                expected_duties.size()));
      expected_duties.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    case (idx)
      CFG_GAIN_P:        gain_p_m   = val;
      CFG_GAIN_I:        gain_i_m   = val;
      CFG_GAIN_D:        gain_d_m   = val;
      CFG_DUTY_MAX:      duty_max_m = val[DUTY_W-1:0];
      CFG_SAMPLE_PERIOD: period_m   = val[PERIOD_W-1:0];
      default: ;
    endcase
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // response side: random stalls plus an optional long hold-off
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      out_ready_i <= 1'b0;
      hold_off_left--;
    end else begin
      out_ready_i <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_duties.size() == 0) begin
        report_mismatch("duty transaction with nothing expected");
      end else begin
        duty_want = expected_duties.pop_front();
        if (out_data_o.left_duty !== duty_want.left_duty)
          report_mismatch($sformatf("left_duty got %0d want %0d",
                                    out_data_o.left_duty, duty_want.left_duty));
        if (out_data_o.right_duty !== duty_want.right_duty)
          report_mismatch($sformatf("right_duty got %0d want %0d",
                                    out_data_o.right_duty, duty_want.right_duty));
      end
    end
  end

  task automatic test_reset_config();
    repeat (8) send_item(tick_item(16'sd3, -16'sd2));
    send_item(ctrl_item(16'sd4, 16'sd20));
    send_item(ctrl_item(16'sd2, -16'sd30));
    drain();
  endtask

  task automatic test_field_extremes();
    write_reg(CFG_SAMPLE_PERIOD, 24'hAB0002);  // upper bits must be dropped
    write_reg(CFG_DUTY_MAX, 24'hFFFFFF);
    send_item(tick_item(WORD_MAX, WORD_MIN));
    send_item(tick_item(WORD_MAX, WORD_MIN));
    send_item(ctrl_item(WORD_MIN, WORD_MAX));
    send_item(ctrl_item(WORD_MAX, WORD_MIN));
    send_item(tick_item(WORD_MIN, WORD_MAX));
    send_item(tick_item(WORD_MIN, WORD_MAX));
    send_item(ctrl_item(WORD_MAX, WORD_MAX));
    drain();
  endtask

  task automatic test_period_edges();
    // zero period latches on every tick
    write_reg(CFG_SAMPLE_PERIOD, '0);
    send_item(tick_item(16'sd5, -16'sd7));
    send_item(ctrl_item(16'sd0, 16'sd0));
    send_item(tick_item(-16'sd9, 16'sd4));
    send_item(ctrl_item(16'sd1, 16'sd1));
    drain();
    // lowering the period under the running count latches on the next tick
    write_reg(CFG_SAMPLE_PERIOD, 24'd6);
    repeat (4) send_item(tick_item(16'sd11, -16'sd13));
    drain();
    write_reg(CFG_SAMPLE_PERIOD, 24'd2);
    send_item(tick_item(16'sd1, 16'sd2));
    send_item(ctrl_item(16'sd40, 16'sd60));
    drain();
  endtask

  task automatic test_gain_extremes();
    write_reg(CFG_GAIN_P, GAIN_MAX);
    write_reg(CFG_GAIN_I, GAIN_MAX);
    write_reg(CFG_GAIN_D, GAIN_MAX);
    write_reg(CFG_DUTY_MAX, 24'hFFFD2C);  // masks to 300
    send_item(ctrl_item(WORD_MAX, WORD_MAX));  // drives saturate high
    send_item(ctrl_item(WORD_MIN, WORD_MIN));
    drain();
    write_reg(CFG_GAIN_P, '0);
    write_reg(CFG_GAIN_I, '0);
    write_reg(CFG_GAIN_D, '0);
    write_reg(CFG_DUTY_MAX, '0);
    send_item(ctrl_item(WORD_MAX, WORD_MIN));
    drain();
    write_reg(CFG_DUTY_MAX, CFG_DATA_W'(DUTY_TOP));
    send_item(ctrl_item(16'sd123, -16'sd45));
    drain();
  endtask

  task automatic test_unused_cfg_index();
    write_reg(CFG_GAIN_P, 24'd65536);
    write_reg(CFG_GAIN_I, 24'd512);
    write_reg(CFG_GAIN_D, 24'd16384);
    for (int idx = CFG_IDX_FIRST_UNUSED; idx < (1 << CFG_IDX_W); idx++)
      write_reg(CFG_IDX_W'(idx), CFG_DATA_W'($urandom));
    send_item(ctrl_item(16'sd300, 16'sd200));
    send_item(ctrl_item(-16'sd50, 16'sd500));
    drain();
  endtask

  task automatic test_output_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_off_left  = 150;
    repeat (24) send_item(ctrl_item(rand_word(150), rand_word(150)));
    drain();
  endtask

  task automatic test_random_traffic(input int send_pct, input int recv_pct, input int n_items);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    repeat (3) begin
      write_reg(CFG_GAIN_P, random_gain());
      write_reg(CFG_GAIN_I, random_gain());
      write_reg(CFG_GAIN_D, random_gain());
      write_reg(CFG_DUTY_MAX, $urandom_range(3) == 0 ? CFG_DATA_W'($urandom)
                                                     : CFG_DATA_W'($urandom_range(DUTY_TOP)));
      write_reg(CFG_SAMPLE_PERIOD, $urandom_range(7) == 0 ? CFG_DATA_W'($urandom)
                                                          : CFG_DATA_W'($urandom_range(12)));
      repeat (n_items / 3) begin
        if ($urandom_range(99) < 65) send_item(tick_item(rand_word(20), rand_word(20)));
        else send_item(ctrl_item(rand_word(150), rand_word(150)));
      end
      drain();
    end
  endtask

  initial begin
    reset_model();
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_config();
    test_field_extremes();
    test_period_edges();
    test_gain_extremes();
    test_unused_cfg_index();
    test_output_backpressure();
    test_random_traffic(0, 0, 300);
    test_random_traffic(54, 0, 300);
    test_random_traffic(0, 54, 300);
    test_random_traffic(30, 30, 300);

    if (error_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
